### hdl/sentinel_rle_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// sentinel_rle_decoder_unit_macros.svh
// assertion macros shared by the decoder modules
// ----------------------------------------------------------------------------
`ifndef SENTINEL_RLE_DECODER_UNIT_MACROS_SVH
`define SENTINEL_RLE_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define SRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/srd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_pkg
// shared constants and the front-to-back command type of the decoder
// ----------------------------------------------------------------------------
package srd_pkg;

    // bytes packed per result, clamped to what out_bytes can hold
    localparam int LANE_BYTES = 4;
    localparam int LANES      = (LANE_BYTES < 1) ? 1 : ((LANE_BYTES > 4) ? 4 : LANE_BYTES);
    localparam logic [2:0] LANES_C = 3'(LANES);

    // command queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // capacity register reset value
    localparam logic [19:0] CAP_RESET = 20'hFFFFF;

    // one decoded action: a run of count copies of value, maybe closing the block
    typedef struct packed {
        logic [7:0]  value;
        logic [7:0]  count;
        logic        last;
        logic [19:0] length;
        logic        err;
    } t_cmd;

endpackage

### hdl/sentinel_rle_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sentinel_rle_decoder_unit
// escape-byte run-length decoder, one compressed byte per input beat
// ----------------------------------------------------------------------------
// The input takes one compressed byte per cycle as long as the 4-entry command
// queue has room. A literal gives one output beat; an escape run of count bytes
// gives ceil(count/4) beats, one per cycle from the expander while the output is
// ready, so a run of up to 255 gives up to 64 beats while the input keeps filling
// the queue and then stalls. The beat closing a block carries block_end, the
// decoded length (0 on error) and the error flag; a block end with no data gives
// one beat with byte_count 0. A command from an accepted byte is written into the
// queue and then loaded into the output register. out_capacity is written through
// i_cfg_we and takes effect for bytes accepted afterwards.
module sentinel_rle_decoder_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [19:0]  i_cfg_wdata,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [7:0]   i_data_byte,
    input  logic         i_block_last,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [31:0]  o_out_bytes,
    output logic [2:0]   o_byte_count,
    output logic         o_item_last,
    output logic         o_block_end,
    output logic [19:0]  o_block_length,
    output logic         o_decode_error
);
    import srd_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_cmd cmd;
    t_cmd head;

    // byte classifier and block state
    srd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_data_byte  (i_data_byte),
        .i_block_last (i_block_last),
        .o_in_ready   (o_in_ready),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (cmd)
    );

    // command queue
    srd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    // run expander and output register
    srd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_bytes    (o_out_bytes),
        .o_byte_count   (o_byte_count),
        .o_item_last    (o_item_last),
        .o_block_end    (o_block_end),
        .o_block_length (o_block_length),
        .o_decode_error (o_decode_error)
    );

endmodule

### hdl/srd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_front
// accepts compressed bytes, tracks escape phase, checks capacity, issues commands
// ----------------------------------------------------------------------------
module srd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [19:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic [7:0]         i_data_byte,
    input  logic               i_block_last,
    output logic               o_in_ready,
    input  logic               i_q_full,
    output logic               o_push,
    output srd_pkg::t_cmd      o_cmd
);
    import srd_pkg::*;

    localparam logic [1:0] PH_SENT = 2'd0;
    localparam logic [1:0] PH_NORM = 2'd1;
    localparam logic [1:0] PH_VAL  = 2'd2;
    localparam logic [1:0] PH_CNT  = 2'd3;

    logic [19:0] r_cap;
    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_esc, n_esc;
    logic [7:0]  r_rep, n_rep;
    logic [19:0] r_len, n_len;
    logic        r_err, n_err;

    logic        in_acc;
    logic        em_req;
    logic [7:0]  em_val;
    logic [7:0]  em_cnt;
    logic [1:0]  ph_step;
    logic [7:0]  esc_step;
    logic [7:0]  rep_step;
    logic [20:0] sum;
    logic        em_ok;
    logic        em_ovf;
    logic [19:0] len_step;
    logic        err_step;
    logic        fin_err;

    assign o_in_ready = !i_q_full;
    assign in_acc     = i_in_valid && !i_q_full;

    // classify the byte by phase
    always_comb begin
        ph_step  = r_phase;
        esc_step = r_esc;
        rep_step = r_rep;
        em_req   = 1'b0;
        em_val   = i_data_byte;
        em_cnt   = 8'd1;
        case (r_phase)
            PH_SENT: begin
                esc_step = i_data_byte;
                ph_step  = PH_NORM;
            end
            PH_NORM: begin
                if (i_data_byte == r_esc) begin
                    ph_step = PH_VAL;
                end else begin
                    em_req = 1'b1;
                end
            end
            PH_VAL: begin
                rep_step = i_data_byte;
                ph_step  = PH_CNT;
            end
            PH_CNT: begin
                em_req  = 1'b1;
                em_val  = r_rep;
                em_cnt  = i_data_byte;
                ph_step = PH_NORM;
            end
            default: begin
                ph_step = PH_SENT;
            end
        endcase
    end

    // capacity check, a run is all or nothing
    assign sum      = {1'b0, r_len} + {13'd0, em_cnt};
    assign em_ok    = em_req && !r_err && (em_cnt != 8'd0) && (sum <= {1'b0, r_cap});
    assign em_ovf   = em_req && !r_err && (em_cnt != 8'd0) && !(sum <= {1'b0, r_cap});
    assign len_step = em_ok ? sum[19:0] : r_len;
    assign err_step = r_err || em_ovf;
    assign fin_err  = err_step || (ph_step == PH_VAL) || (ph_step == PH_CNT);

    // block close returns all block state to reset
    always_comb begin
        n_phase = ph_step;
        n_esc   = esc_step;
        n_rep   = rep_step;
        n_len   = len_step;
        n_err   = err_step;
        if (i_block_last) begin
            n_phase = PH_SENT;
            n_esc   = 8'd0;
            n_rep   = 8'd0;
            n_len   = 20'd0;
            n_err   = 1'b0;
        end
    end

    // command to the back end
    assign o_push       = in_acc && (em_ok || i_block_last);
    assign o_cmd.value  = em_val;
    assign o_cmd.count  = em_ok ? em_cnt : 8'd0;
    assign o_cmd.last   = i_block_last;
    assign o_cmd.length = fin_err ? 20'd0 : len_step;
    assign o_cmd.err    = i_block_last ? fin_err : 1'b0;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SENT;
            r_esc   <= 8'd0;
            r_rep   <= 8'd0;
            r_len   <= 20'd0;
            r_err   <= 1'b0;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_rep   <= n_rep;
            r_len   <= n_len;
            r_err   <= n_err;
        end
    end

endmodule

### hdl/srd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_queue
// small command queue between front and back
// ----------------------------------------------------------------------------
module srd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  srd_pkg::t_cmd      i_cmd,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output srd_pkg::t_cmd      o_head
);
    import srd_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### hdl/srd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_back
// expands queued commands into packed result beats, one per cycle while output is ready
// ----------------------------------------------------------------------------
`include "sentinel_rle_decoder_unit_macros.svh"

module srd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  srd_pkg::t_cmd      i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_out_bytes,
    output logic [2:0]         o_byte_count,
    output logic               o_item_last,
    output logic               o_block_end,
    output logic [19:0]        o_block_length,
    output logic               o_decode_error
);
    import srd_pkg::*;

    logic        r_valid;
    logic [7:0]  r_sent;
    logic [31:0] r_bytes;
    logic [2:0]  r_count;
    logic        r_item_last;
    logic        r_block_end;
    logic [19:0] r_length;
    logic        r_error;

    logic        load;
    logic [7:0]  rem;
    logic        fin;
    logic [2:0]  take;
    logic [31:0] word;

    // chunk of the head command
    assign load  = !r_valid || i_out_ready;
    assign rem   = i_head.count - r_sent;
    assign fin   = (rem <= {5'd0, LANES_C});
    assign take  = fin ? rem[2:0] : LANES_C;
    assign o_pop = load && !i_q_empty && fin;

    // fill lanes below take with the value
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            word[8*j +: 8] = (3'(j) < take) ? i_head.value : 8'd0;
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sent  <= 8'd0;
        end else if (load) begin
            r_valid <= !i_q_empty;
            if (!i_q_empty) begin
                r_sent <= fin ? 8'd0 : (r_sent + 8'(LANES));
            end
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (load && !i_q_empty) begin
            r_bytes     <= word;
            r_count     <= take;
            r_item_last <= fin;
            r_block_end <= fin && i_head.last;
            r_length    <= (fin && i_head.last) ? i_head.length : 20'd0;
            r_error     <= i_head.err;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_out_bytes    = r_bytes;
    assign o_byte_count   = r_count;
    assign o_item_last    = r_item_last;
    assign o_block_end    = r_block_end;
    assign o_block_length = r_length;
    assign o_decode_error = r_error;

    `SRD_ASSERT_IMP(a_full_chunk, i_clk, i_rst_n, r_valid && !r_item_last, r_count == LANES_C, "non-final beat is not full")
    `SRD_ASSERT_IMP(a_end_is_last, i_clk, i_rst_n, r_valid && r_block_end, r_item_last, "block end off the last beat")
    `SRD_ASSERT_IMP(a_err_no_data, i_clk, i_rst_n, r_valid && r_error, r_count == 3'd0 && r_length == 20'd0, "error beat carries data")
    `SRD_ASSERT_NXT(a_sent_moves, i_clk, i_rst_n, load && !i_q_empty && !fin, r_sent != 8'd0, "run counter did not advance")

endmodule
